>>> rtl/core/bmpq_pkg.sv
// Shared types, constants and quantizer helpers for the BMP row unpack block.
package bmpq_pkg;

  localparam int unsigned MAX_WIDTH_DEF   = 2048;
  localparam int unsigned REMAP_DEPTH_DEF = 256;
  localparam int unsigned QUEUE_DEPTH     = 4;

  // Fixed widths set by the register and field formats
  localparam int unsigned CFGW = 12;  // widest register
  localparam int unsigned COLW = 13;  // column counter, saturating past 12 bits
  localparam int unsigned LENW = 15;  // data length / stride arithmetic

  localparam logic [1:0] FMT_4BPP  = 2'd0;
  localparam logic [1:0] FMT_8BPP  = 2'd1;
  localparam logic [1:0] FMT_24BPP = 2'd2;

  localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_CLIP_START   = 2'd2;
  localparam logic [1:0] CFG_CLIP_END     = 2'd3;

  localparam logic [1:0]  RST_PIXEL_FORMAT = FMT_8BPP;
  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd1;
  localparam logic [11:0] RST_CLIP_START   = 12'd0;
  localparam logic [11:0] RST_CLIP_END     = 12'd2048;

  localparam logic [5:0] THR_BLACK = 6'd10;
  localparam logic [5:0] THR_1     = 6'd26;
  localparam logic [5:0] THR_2     = 6'd38;
  localparam logic [5:0] THR_3     = 6'd50;
  localparam logic [5:0] THR_4     = 6'd54;
  localparam logic [5:0] THR_5     = 6'd59;
  localparam logic [5:0] THR_WHITE = 6'd62;

  localparam logic [7:0] RED_STEP   = 8'd36;
  localparam logic [7:0] RED_TOP    = 8'd180;
  localparam logic [7:0] WHITE_CODE = 8'd15;
  localparam logic [7:0] BLACK_CODE = 8'd0;
  localparam logic [7:0] NIB_HI     = 8'hf0;
  localparam logic [7:0] NIB_LO     = 8'h0f;

  typedef struct packed {
    logic       vld;
    logic       direct;  // val is the final pixel value, no table lookup
    logic [7:0] val;     // table index, or final value when direct
    logic [11:0] col;
  } pix_t;

  typedef struct packed {
    logic       is_wr;
    logic [7:0] wr_idx;
    logic [7:0] wr_val;
    pix_t       p0;
    pix_t       p1;
  } entry_t;

  function automatic logic [2:0] level_of(input logic [5:0] v);
    logic [2:0] l;
    if (v <= THR_1)     l = 3'd0;
    else if (v < THR_2) l = 3'd1;
    else if (v < THR_3) l = 3'd2;
    else if (v < THR_4) l = 3'd3;
    else if (v < THR_5) l = 3'd4;
    else                l = 3'd5;
    return l;
  endfunction

  // red uses a strict compare at the first threshold, unlike level_of
  function automatic logic [7:0] red_base(input logic [5:0] r);
    logic [7:0] c;
    if (r < THR_1)      c = 8'd0;
    else if (r < THR_2) c = RED_STEP;
    else if (r < THR_3) c = 8'(2 * RED_STEP);
    else if (r < THR_4) c = 8'(3 * RED_STEP);
    else if (r < THR_5) c = 8'(4 * RED_STEP);
    else                c = RED_TOP;
    return c;
  endfunction

  function automatic logic [7:0] cube_index(input logic [5:0] r, input logic [5:0] g,
                                            input logic [5:0] b);
    logic [7:0] gl;
    logic [7:0] bl;
    gl = {5'd0, level_of(g)};
    bl = {5'd0, level_of(b)};
    return red_base(r) + (gl << 2) + (gl << 1) + bl;
  endfunction

endpackage

>>> rtl/core/bmpq_ram.sv
// Generic simple dual-port RAM with registered read.
module bmpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bmpq_front.sv
// Front end: config registers, row byte tracking, unpack, quantize and clip.
module bmpq_front #(
  parameter int unsigned MAX_WIDTH   = bmpq_pkg::MAX_WIDTH_DEF,
  parameter int unsigned REMAP_DEPTH = bmpq_pkg::REMAP_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [bmpq_pkg::CFGW-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic [7:0]            in_data_byte,
  input  logic [7:0]            in_table_index,
  input  logic [7:0]            in_table_value,
  input  logic                  q_full,
  output logic                  q_push,
  output bmpq_pkg::entry_t      q_entry
);

  localparam int unsigned WMAX       = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;
  localparam int unsigned STRIDE_MAX = ((WMAX * 24 + 31) / 32) * 4;
  localparam int unsigned CW         = $clog2(STRIDE_MAX + 1);
  localparam logic [12:0] WCAP       = 13'(WMAX);
  localparam logic [8:0]  DEPTH9     = 9'(REMAP_DEPTH);
  localparam int unsigned COLW       = bmpq_pkg::COLW;
  localparam int unsigned LENW       = bmpq_pkg::LENW;

  logic [1:0]  fmt_r;
  logic [11:0] width_r, clip_start_r, clip_end_r;

  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [5:0]      blue_r, blue_nxt, green_r, green_nxt;

  logic [11:0]     w;
  logic [LENW-1:0] w_l, w3, data_len, stride, cnt_inc;
  logic [COLW-1:0] col1, col2;
  logic            accept;

  logic       pa_has, pa_direct, pb_has, pb_direct;
  logic [7:0] pa_val, pb_val;
  logic       pa_emit, pb_emit;
  bmpq_pkg::pix_t pa, pb;
  logic [5:0] red6;

  function automatic logic [COLW-1:0] sat_inc(input logic [COLW-1:0] c);
    return (&c) ? c : c + COLW'(1);
  endfunction

  function automatic logic in_clip(input logic [COLW-1:0] c, input logic [11:0] lo,
                                   input logic [11:0] hi);
    return (c > {1'b0, lo}) && (c < {1'b0, hi});
  endfunction

  // index past the table end reads as zero
  function automatic bmpq_pkg::pix_t mk_pix(input logic emit, input logic direct,
                                            input logic [7:0] v,
                                            input logic [COLW-1:0] c);
    bmpq_pkg::pix_t p;
    p.vld    = emit;
    p.col    = c[11:0];
    if (!direct && ({1'b0, v} >= DEPTH9)) begin
      p.direct = 1'b1;
      p.val    = 8'd0;
    end else begin
      p.direct = direct;
      p.val    = v;
    end
    return p;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r        <= bmpq_pkg::RST_PIXEL_FORMAT;
      width_r      <= bmpq_pkg::RST_IMAGE_WIDTH;
      clip_start_r <= bmpq_pkg::RST_CLIP_START;
      clip_end_r   <= bmpq_pkg::RST_CLIP_END;
    end else if (cfg_valid) begin
      case (cfg_index)
        bmpq_pkg::CFG_PIXEL_FORMAT: fmt_r        <= cfg_wdata[1:0];
        bmpq_pkg::CFG_IMAGE_WIDTH:  width_r      <= cfg_wdata[11:0];
        bmpq_pkg::CFG_CLIP_START:   clip_start_r <= cfg_wdata[11:0];
        bmpq_pkg::CFG_CLIP_END:     clip_end_r   <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // effective width, data bytes and padded stride of one row
  always_comb begin
    if (width_r == 12'd0)            w = 12'd1;
    else if ({1'b0, width_r} > WCAP) w = WCAP[11:0];
    else                             w = width_r;
    w_l = LENW'(w);
    w3  = (w_l << 1) + w_l;
    case (fmt_r)
      bmpq_pkg::FMT_4BPP: begin
        data_len = (w_l + LENW'(1)) >> 1;
        stride   = ((w_l + LENW'(7)) >> 3) << 2;
      end
      bmpq_pkg::FMT_24BPP: begin
        data_len = w3;
        stride   = ((w3 + LENW'(3)) >> 2) << 2;
      end
      default: begin
        data_len = w_l;
        stride   = ((w_l + LENW'(3)) >> 2) << 2;
      end
    endcase
  end

  always_comb begin
    col1      = sat_inc(col_r);
    col2      = sat_inc(col1);
    red6      = in_data_byte[7:2];
    pa_has    = 1'b0;
    pa_direct = 1'b0;
    pa_val    = in_data_byte;
    pb_has    = 1'b0;
    pb_direct = 1'b0;
    pb_val    = in_data_byte & bmpq_pkg::NIB_LO;
    col_nxt   = col_r;
    phase_nxt = phase_r;
    blue_nxt  = blue_r;
    green_nxt = green_r;
    if (LENW'(cnt_r) < data_len) begin
      case (fmt_r)
        bmpq_pkg::FMT_4BPP: begin
          pa_has = 1'b1;
          pa_val = (in_data_byte & bmpq_pkg::NIB_HI) >> 4;
          // odd width: low nibble of the last byte is not a pixel
          if (col1 <= {1'b0, w}) begin
            pb_has  = 1'b1;
            col_nxt = col2;
          end else begin
            col_nxt = col1;
          end
        end
        bmpq_pkg::FMT_24BPP: begin
          if (phase_r == 2'd0) begin
            blue_nxt  = red6;
            phase_nxt = 2'd1;
          end else if (phase_r == 2'd1) begin
            green_nxt = red6;
            phase_nxt = 2'd2;
          end else begin
            pa_has    = 1'b1;
            phase_nxt = 2'd0;
            col_nxt   = col1;
            if (red6 < bmpq_pkg::THR_BLACK && green_r < bmpq_pkg::THR_BLACK &&
                blue_r < bmpq_pkg::THR_BLACK) begin
              pa_direct = 1'b1;
              pa_val    = bmpq_pkg::BLACK_CODE;
            end else if (red6 > bmpq_pkg::THR_WHITE && green_r > bmpq_pkg::THR_WHITE &&
                         blue_r > bmpq_pkg::THR_WHITE) begin
              pa_direct = 1'b1;
              pa_val    = bmpq_pkg::WHITE_CODE;
            end else begin
              pa_val = bmpq_pkg::cube_index(red6, green_r, blue_r);
            end
          end
        end
        default: begin
          pa_has  = 1'b1;
          col_nxt = col1;
        end
      endcase
    end
    cnt_inc = LENW'(cnt_r) + LENW'(1);
    if (cnt_inc >= stride) begin
      cnt_nxt   = '0;
      col_nxt   = COLW'(1);
      phase_nxt = 2'd0;
    end else begin
      cnt_nxt = cnt_inc[CW-1:0];
    end
  end

  assign pa_emit = pa_has && in_clip(col_r, clip_start_r, clip_end_r);
  assign pb_emit = pb_has && in_clip(col1, clip_start_r, clip_end_r);
  assign pa      = mk_pix(pa_emit, pa_direct, pa_val, col_r);
  assign pb      = mk_pix(pb_emit, pb_direct, pb_val, col1);

  // a queued pixel word always has its first pixel in p0
  always_comb begin
    q_entry.is_wr  = in_mode;
    q_entry.wr_idx = in_table_index;
    q_entry.wr_val = in_table_value;
    if (pa_emit) begin
      q_entry.p0 = pa;
      q_entry.p1 = pb;
    end else begin
      q_entry.p0 = pb;
      q_entry.p1 = '0;
    end
    if (in_mode) begin
      q_push = accept && ({1'b0, in_table_index} < DEPTH9);
    end else begin
      q_push = accept && (pa_emit || pb_emit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      col_r   <= COLW'(1);
      phase_r <= 2'd0;
      blue_r  <= 6'd0;
      green_r <= 6'd0;
    end else if (accept && !in_mode) begin
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
    end
  end

endmodule

>>> rtl/core/bmpq_fifo.sv
// Short queue of classified words between front end and lookup back end.
module bmpq_fifo #(
  parameter int unsigned DEPTH = bmpq_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bmpq_pkg::entry_t wdata,
  input  logic             pop,
  output bmpq_pkg::entry_t rdata,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  bmpq_pkg::entry_t slots [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [NW-1:0] cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full  = (cnt_r == NW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slots[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + NW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ptr_inc(wp_r);
      if (pop)  rp_r <= ptr_inc(rp_r);
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");

endmodule

>>> rtl/core/bmpq_back.sv
// Back end: remap table writes, lookups and the output register.
module bmpq_back #(
  parameter int unsigned REMAP_DEPTH = bmpq_pkg::REMAP_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bmpq_pkg::entry_t head,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_pixel_value,
  output logic [11:0]      out_column,
  output logic             out_last_of_item
);

  localparam int unsigned AW = $clog2(REMAP_DEPTH);

  logic        sub_r, sub_nxt;
  logic        ov_r, ov_nxt;
  logic        od_r;
  logic [7:0]  odv_r;
  logic [11:0] ocol_r;
  logic        olast_r;

  logic           can_issue, issue, ram_we, cur_last;
  bmpq_pkg::pix_t cur;
  logic [7:0]     ram_rdata;

  assign cur       = sub_r ? head.p1 : head.p0;
  assign cur_last  = sub_r || !head.p1.vld;
  assign can_issue = !ov_r || !out_stall;
  assign ram_we    = !q_empty && head.is_wr;
  assign issue     = !q_empty && !head.is_wr && can_issue;
  assign q_pop     = ram_we || (issue && cur_last);

  bmpq_ram #(
    .WIDTH (8),
    .DEPTH (REMAP_DEPTH)
  ) u_remap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.wr_idx[AW-1:0]),
    .wdata (head.wr_val),
    .re    (issue),
    .raddr (cur.val[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    sub_nxt = sub_r;
    if (issue) sub_nxt = !cur_last;
    if (issue)             ov_nxt = 1'b1;
    else if (!out_stall)   ov_nxt = 1'b0;
    else                   ov_nxt = ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      od_r    <= cur.direct;
      odv_r   <= cur.val;
      ocol_r  <= cur.col;
      olast_r <= cur_last;
    end
  end

  // RAM read data holds while the word waits, since reads fire only on issue
  assign out_valid        = ov_r;
  assign out_pixel_value  = od_r ? odv_r : ram_rdata;
  assign out_column       = ocol_r;
  assign out_last_of_item = olast_r;

  a_p0_first: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && !head.is_wr) |-> head.p0.vld)
    else $error("pixel word without first pixel");
  a_sub_has_p1: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (!q_empty && !head.is_wr && head.p1.vld))
    else $error("second-pixel phase with no second pixel");
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (!ov_r || !out_stall))
    else $error("table read while output word is held");

endmodule

>>> rtl/core/bmp_row_pixel_unpack_quantize_top.sv
// Top level: BMP row byte unpack, 6x6x6 quantize, clip and palette remap.
// Takes one byte or table write per clock while in_stall is low; an accepted
// byte's first result passes the queue register, then the remap RAM read
// register. Results leave one per clock while out_stall is low, so 4 bpp bytes
// yielding two pixels outpace them; the 4-word queue absorbs short bursts.
// rst_n is synchronous, active low: registers take their defaults and row
// state restarts; the remap table is not cleared and must be written before use.
module bmp_row_pixel_unpack_quantize_top #(
  parameter int unsigned MAX_WIDTH   = bmpq_pkg::MAX_WIDTH_DEF,
  parameter int unsigned REMAP_DEPTH = bmpq_pkg::REMAP_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_table_index,
  input  logic [7:0]  in_table_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_value,
  output logic [11:0] out_column,
  output logic        out_last_of_item
);

  logic             q_push, q_pop, q_full, q_empty;
  bmpq_pkg::entry_t q_wdata, q_head;

  bmpq_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .REMAP_DEPTH (REMAP_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_data_byte   (in_data_byte),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_wdata)
  );

  bmpq_fifo #(
    .DEPTH (bmpq_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  bmpq_back #(
    .REMAP_DEPTH (REMAP_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_value  (out_pixel_value),
    .out_column       (out_column),
    .out_last_of_item (out_last_of_item)
  );

endmodule

>>> test/tb_bmp_row_pixel_unpack_quantize_top.sv
// Testbench for the BMP row unpack / color cube quantize block, self-checking against a predictor.
module tb_bmp_row_pixel_unpack_quantize_top;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned RANDOM_ITEMS  = 560;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_TABLE = 1'b1;
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  localparam logic [5:0] DARK_LIMIT   = 6'd10;
  localparam logic [5:0] BRIGHT_LIMIT = 6'd62;
  localparam logic [5:0] LVL_CUT1 = 6'd26;
  localparam logic [5:0] LVL_CUT2 = 6'd38;
  localparam logic [5:0] LVL_CUT3 = 6'd50;
  localparam logic [5:0] LVL_CUT4 = 6'd54;
  localparam logic [5:0] LVL_CUT5 = 6'd59;
  localparam int unsigned RED_WEIGHT   = 36;
  localparam int unsigned GREEN_WEIGHT = 6;
  localparam logic [7:0] BLACK_OUT = 8'd0;
  localparam logic [7:0] WHITE_OUT = 8'd15;

  typedef struct packed {
    logic [7:0]  value;
    logic [11:0] col;
    logic        last;
  } pix_res_t;

  typedef enum logic [1:0] {STEP_BYTE, STEP_TABLE, STEP_REG} step_kind_t;
  typedef enum logic [1:0] {WANT_BLUE, WANT_GREEN, WANT_RED} gather_t;

  typedef struct packed {
    step_kind_t  kind;
    logic [1:0]  reg_idx;
    logic [11:0] reg_val;
    logic [7:0]  data;
    logic [7:0]  tidx;
    logic [7:0]  tval;
    logic        typed;
    logic [1:0]  n_exp;
    pix_res_t    ra;
    pix_res_t    rb;
  } plan_row_t;

  localparam pix_res_t NO_PIX = '0;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [7:0]  in_data_byte;
  logic [7:0]  in_table_index;
  logic [7:0]  in_table_value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_pixel_value;
  logic [11:0] out_column;
  logic        out_last_of_item;

  // expectation carried alongside the payload for directed rows
  logic        typed_row;
  logic [1:0]  typed_n;
  pix_res_t    typed_a;
  pix_res_t    typed_b;

  bmp_row_pixel_unpack_quantize_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_data_byte     (in_data_byte),
    .in_table_index   (in_table_index),
    .in_table_value   (in_table_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_value  (out_pixel_value),
    .out_column       (out_column),
    .out_last_of_item (out_last_of_item)
  );

  // predictor state
  logic [1:0]  fmt_reg;
  logic [11:0] width_reg;
  logic [11:0] clip_lo;
  logic [11:0] clip_hi;
  logic [7:0]  remap_mem [256];
  int unsigned row_bytes;
  int unsigned next_col;
  gather_t     comp_phase;
  logic [5:0]  blue_hold;
  logic [5:0]  green_hold;

  pix_res_t    step_out[$];
  pix_res_t    pending_pixels[$];
  plan_row_t   directed_plan[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          long_hold = 1'b0;
  bit          src_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  bit          cfg_open = 1'b0;
  bit          in_flight = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void reset_model();
    fmt_reg    = bmpq_pkg::FMT_8BPP;
    width_reg  = 12'd1;
    clip_lo    = 12'd0;
    clip_hi    = 12'd2048;
    row_bytes  = 0;
    next_col   = 1;
    comp_phase = WANT_BLUE;
    blue_hold  = '0;
    green_hold = '0;
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [11:0] val);
    case (idx)
      bmpq_pkg::CFG_PIXEL_FORMAT: fmt_reg = val[1:0];
      bmpq_pkg::CFG_IMAGE_WIDTH:  width_reg = val;
      bmpq_pkg::CFG_CLIP_START:   clip_lo = val;
      bmpq_pkg::CFG_CLIP_END:     clip_hi = val;
      default: ;
    endcase
  endfunction

  // green and blue bands; red differs only in taking the first cut inclusively
  function automatic int unsigned shade_level(input logic [5:0] v, input bit red);
    int unsigned lvl;
    lvl = 0;
    if (v > LVL_CUT1 || (red && v == LVL_CUT1)) lvl = 1;
    if (v >= LVL_CUT2) lvl = 2;
    if (v >= LVL_CUT3) lvl = 3;
    if (v >= LVL_CUT4) lvl = 4;
    if (v >= LVL_CUT5) lvl = 5;
    return lvl;
  endfunction

  function automatic logic [7:0] cube_color(input logic [5:0] r, input logic [5:0] g,
                                            input logic [5:0] b);
    int unsigned idx;
    if (r < DARK_LIMIT && g < DARK_LIMIT && b < DARK_LIMIT) return BLACK_OUT;
    if (r > BRIGHT_LIMIT && g > BRIGHT_LIMIT && b > BRIGHT_LIMIT) return WHITE_OUT;
    idx = RED_WEIGHT * shade_level(r, 1'b1) + GREEN_WEIGHT * shade_level(g, 1'b0)
          + shade_level(b, 1'b0);
    return remap_mem[idx[7:0]];
  endfunction

  function automatic void place_pixel(input logic [7:0] v);
    pix_res_t p;
    if (next_col > clip_lo && next_col < clip_hi) begin
      p.value = v;
      p.col   = next_col[11:0];
      p.last  = 1'b0;
      step_out.push_back(p);
    end
    next_col++;
  endfunction

  function automatic void predict_pixels(input logic [7:0] b);
    int unsigned w;
    int unsigned bpp;
    int unsigned data_len;
    int unsigned stride;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > bmpq_pkg::MAX_WIDTH_DEF) w = bmpq_pkg::MAX_WIDTH_DEF;
    case (fmt_reg)
      bmpq_pkg::FMT_4BPP:  begin bpp = 4;  data_len = (w + 1) / 2; end
      bmpq_pkg::FMT_24BPP: begin bpp = 24; data_len = 3 * w; end
      default:             begin bpp = 8;  data_len = w; end
    endcase
    stride = ((w * bpp + 31) / 32) * 4;
    if (row_bytes < data_len) begin
      case (fmt_reg)
        bmpq_pkg::FMT_4BPP: begin
          place_pixel(remap_mem[{4'h0, b[7:4]}]);
          if (next_col <= w) place_pixel(remap_mem[{4'h0, b[3:0]}]);
        end
        bmpq_pkg::FMT_24BPP: begin
          case (comp_phase)
            WANT_BLUE: begin
              blue_hold  = b[7:2];
              comp_phase = WANT_GREEN;
            end
            WANT_GREEN: begin
              green_hold = b[7:2];
              comp_phase = WANT_RED;
            end
            default: begin
              place_pixel(cube_color(b[7:2], green_hold, blue_hold));
              comp_phase = WANT_BLUE;
            end
          endcase
        end
        default: place_pixel(remap_mem[b]);
      endcase
    end
    row_bytes++;
    if (row_bytes >= stride) begin
      row_bytes  = 0;
      next_col   = 1;
      comp_phase = WANT_BLUE;
    end
  endfunction

  function automatic void accept_word();
    step_out.delete();
    if (in_mode == MODE_TABLE) remap_mem[in_table_index] = in_table_value;
    else predict_pixels(in_data_byte);
    if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
    if (typed_row) begin
      if (typed_n > 0) pending_pixels.push_back(typed_a);
      if (typed_n > 1) pending_pixels.push_back(typed_b);
    end else begin
      foreach (step_out[i]) pending_pixels.push_back(step_out[i]);
    end
  endfunction

  function automatic void check_word();
    pix_res_t want;
    if (pending_pixels.size() == 0) begin
      $error("word with nothing expected: pixel_value %0d column %0d",
             out_pixel_value, out_column);
      mismatch_count++;
      return;
    end
    want = pending_pixels.pop_front();
    if (out_pixel_value !== want.value) begin
      $error("pixel_value: expected %0d, got %0d", want.value, out_pixel_value);
      mismatch_count++;
    end
    if (out_column !== want.col) begin
      $error("column: expected %0d, got %0d", want.col, out_column);
      mismatch_count++;
    end
    if (out_last_of_item !== want.last) begin
      $error("last_of_item: expected %0d, got %0d", want.last, out_last_of_item);
      mismatch_count++;
    end
  endfunction

  // handshakes are judged on the values held just before the edge
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) accept_word();
      if (out_valid && !out_stall) check_word();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned pause;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) sink_quiet = !sink_quiet;
      pause = sink_quiet ? 0 : $urandom_range(0, 13);
      if (pause != 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  function automatic pix_res_t px(input logic [7:0] v, input logic [11:0] c, input logic l);
    pix_res_t p;
    p.value = v;
    p.col   = c;
    p.last  = l;
    return p;
  endfunction

  function automatic plan_row_t typed_byte(input logic [7:0] d, input logic [1:0] n,
                                           input pix_res_t a, input pix_res_t b);
    plan_row_t r;
    r       = '0;
    r.kind  = STEP_BYTE;
    r.data  = d;
    r.typed = 1'b1;
    r.n_exp = n;
    r.ra    = a;
    r.rb    = b;
    return r;
  endfunction

  function automatic plan_row_t free_byte(input logic [7:0] d);
    plan_row_t r;
    r      = '0;
    r.kind = STEP_BYTE;
    r.data = d;
    return r;
  endfunction

  function automatic plan_row_t table_row(input logic [7:0] i, input logic [7:0] v);
    plan_row_t r;
    r      = '0;
    r.kind = STEP_TABLE;
    r.tidx = i;
    r.tval = v;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [1:0] i, input logic [11:0] v);
    plan_row_t r;
    r         = '0;
    r.kind    = STEP_REG;
    r.reg_idx = i;
    r.reg_val = v;
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 39));
      1:       return 8'($urandom_range(8'hf8, 8'hff));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_word(input logic mode, input logic [7:0] data, input logic [7:0] tidx,
                           input logic [7:0] tval, input logic typed, input logic [1:0] n,
                           input pix_res_t ra, input pix_res_t rb);
    int unsigned gap;
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    if ($urandom_range(0, 31) == 0) src_quiet = !src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_data_byte   <= data;
    in_table_index <= tidx;
    in_table_value <= tval;
    typed_row      <= typed;
    typed_n        <= n;
    typed_a        <= ra;
    typed_b        <= rb;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    in_flight = 1'b1;
  endtask

  task automatic send_pixel(input logic [7:0] data);
    send_word(MODE_PIXEL, data, 8'($urandom), 8'($urandom), 1'b0, 2'd0, NO_PIX, NO_PIX);
  endtask

  task automatic send_table(input logic [7:0] idx, input logic [7:0] val);
    send_word(MODE_TABLE, 8'($urandom), idx, val, 1'b0, 2'd0, NO_PIX, NO_PIX);
  endtask

  // wait out all results plus the pipeline, so that padding words have left too
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    in_flight = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    if (in_flight) settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_open = 1'b1;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
  endtask

  initial begin : stimulus
    plan_row_t   row;
    logic [1:0]  new_fmt;
    logic [11:0] new_width;
    logic [11:0] new_lo;
    logic [11:0] new_hi;
    bit          all_regs;
    int unsigned burst;
    int unsigned phase_no;
    int unsigned random_items;

    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_mode        = MODE_PIXEL;
    in_data_byte   = '0;
    in_table_index = '0;
    in_table_value = '0;
    typed_row      = 1'b0;
    typed_n        = '0;
    typed_a        = NO_PIX;
    typed_b        = NO_PIX;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // the remap table powers up unknown: write every entry before any lookup
    for (int i = 0; i < 256; i++) send_table(8'(i), 8'(255 - i));

    // 8 bpp, width 1: one pixel then three padding words per row
    directed_plan.push_back(typed_byte(8'h00, 2'd1, px(8'hff, 12'd1, 1'b1), NO_PIX));
    directed_plan.push_back(typed_byte(8'hff, 2'd0, NO_PIX, NO_PIX));
    directed_plan.push_back(typed_byte(8'h80, 2'd0, NO_PIX, NO_PIX));
    directed_plan.push_back(typed_byte(8'h7f, 2'd0, NO_PIX, NO_PIX));
    directed_plan.push_back(table_row(8'h00, 8'h3c));
    directed_plan.push_back(table_row(8'hff, 8'hc3));
    directed_plan.push_back(typed_byte(8'hff, 2'd1, px(8'hc3, 12'd1, 1'b1), NO_PIX));
    // switch to 4 bpp mid-row, then a full odd-width row
    directed_plan.push_back(reg_row(bmpq_pkg::CFG_PIXEL_FORMAT, {10'd0, bmpq_pkg::FMT_4BPP}));
    directed_plan.push_back(reg_row(bmpq_pkg::CFG_IMAGE_WIDTH, 12'd3));
    directed_plan.push_back(free_byte(8'h12));
    directed_plan.push_back(free_byte(8'h5a));
    directed_plan.push_back(free_byte(8'ha5));
    directed_plan.push_back(typed_byte(8'h12, 2'd2, px(8'hfe, 12'd1, 1'b0),
                                       px(8'hfd, 12'd2, 1'b1)));
    directed_plan.push_back(typed_byte(8'hf0, 2'd1, px(8'hf0, 12'd3, 1'b1), NO_PIX));
    directed_plan.push_back(free_byte(8'h00));
    directed_plan.push_back(free_byte(8'hff));
    // 24 bpp: near-black, near-white, then an ordinary cube lookup
    directed_plan.push_back(reg_row(bmpq_pkg::CFG_PIXEL_FORMAT,
                                    {10'd0, bmpq_pkg::FMT_24BPP}));
    directed_plan.push_back(reg_row(bmpq_pkg::CFG_IMAGE_WIDTH, 12'd1));
    directed_plan.push_back(typed_byte(8'h00, 2'd0, NO_PIX, NO_PIX));
    directed_plan.push_back(typed_byte(8'h00, 2'd0, NO_PIX, NO_PIX));
    directed_plan.push_back(typed_byte(8'h00, 2'd1, px(BLACK_OUT, 12'd1, 1'b1), NO_PIX));
    directed_plan.push_back(free_byte(8'h7e));
    directed_plan.push_back(typed_byte(8'hff, 2'd0, NO_PIX, NO_PIX));
    directed_plan.push_back(typed_byte(8'hff, 2'd0, NO_PIX, NO_PIX));
    directed_plan.push_back(typed_byte(8'hff, 2'd1, px(WHITE_OUT, 12'd1, 1'b1), NO_PIX));
    directed_plan.push_back(free_byte(8'h81));
    directed_plan.push_back(free_byte(8'h68));
    directed_plan.push_back(free_byte(8'h6c));
    directed_plan.push_back(free_byte(8'h68));
    // unused format code acts as 8 bpp; narrow clip window
    directed_plan.push_back(reg_row(bmpq_pkg::CFG_PIXEL_FORMAT, {10'd0, FMT_UNUSED}));
    directed_plan.push_back(reg_row(bmpq_pkg::CFG_IMAGE_WIDTH, 12'd4));
    directed_plan.push_back(reg_row(bmpq_pkg::CFG_CLIP_START, 12'd1));
    directed_plan.push_back(reg_row(bmpq_pkg::CFG_CLIP_END, 12'd3));
    directed_plan.push_back(free_byte(8'h01));
    directed_plan.push_back(free_byte(8'h55));
    directed_plan.push_back(free_byte(8'haa));

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      case (row.kind)
        STEP_REG:   write_reg(row.reg_idx, row.reg_val);
        STEP_TABLE: send_table(row.tidx, row.tval);
        default:    send_word(MODE_PIXEL, row.data, 8'($urandom), 8'($urandom),
                              row.typed, row.n_exp, row.ra, row.rb);
      endcase
    end

    phase_no     = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase_no)
        0: begin
          new_fmt = bmpq_pkg::FMT_24BPP; new_width = 12'd4095;
          new_lo = 12'd0; new_hi = 12'd4095;
        end
        1: begin
          new_fmt = bmpq_pkg::FMT_4BPP; new_width = 12'd0;
          new_lo = 12'd4095; new_hi = 12'd0;
        end
        2: begin
          new_fmt = bmpq_pkg::FMT_8BPP; new_width = 12'd2048;
          new_lo = 12'd0; new_hi = 12'd2048;
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       new_fmt = FMT_UNUSED;
            1, 2, 3: new_fmt = bmpq_pkg::FMT_4BPP;
            4, 5, 6: new_fmt = bmpq_pkg::FMT_24BPP;
            default: new_fmt = bmpq_pkg::FMT_8BPP;
          endcase
          case ($urandom_range(0, 11))
            0:       new_width = 12'd0;
            1:       new_width = 12'd4095;
            2:       new_width = 12'd2048;
            default: new_width = 12'($urandom_range(1, 24));
          endcase
          new_lo = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 4095))
                                               : 12'($urandom_range(0, 3));
          new_hi = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 4095))
                                               : 12'(new_width + $urandom_range(0, 3));
        end
      endcase
      all_regs = (phase_no < 3) || ($urandom_range(0, 3) == 0);
      if (all_regs || $urandom_range(0, 3) != 0)
        write_reg(bmpq_pkg::CFG_PIXEL_FORMAT, {10'd0, new_fmt});
      if (all_regs || $urandom_range(0, 3) != 0)
        write_reg(bmpq_pkg::CFG_IMAGE_WIDTH, new_width);
      if (all_regs || $urandom_range(0, 3) != 0)
        write_reg(bmpq_pkg::CFG_CLIP_START, new_lo);
      if (all_regs || $urandom_range(0, 3) != 0)
        write_reg(bmpq_pkg::CFG_CLIP_END, new_hi);

      // one long output hold while words keep coming in
      if (phase_no == 2) long_hold = 1'b1;
      // wide rows are slow to finish; keep those phases short
      burst = (new_width > 64) ? $urandom_range(16, 32) : $urandom_range(20, 70);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 11) == 0) send_table(8'($urandom), 8'($urandom));
        else send_pixel(pick_byte());
      end
      random_items += burst;
      phase_no++;
    end

    settle();
    if (mismatch_count == 0 && pending_pixels.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
